>>> design/rbs_pkg.sv
// Shared types and constants for the RGBA bilinear sampler.
package rbs_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;
  localparam int DEF_FRAC_BITS  = 8;

  localparam int POS_W = 14;
  localparam int PIX_W = 32;
  localparam int CMD_W = 2;
  localparam int CFG_W = 7;
  localparam int IDX_W = 1;

  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd2;

  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] IMAGE_SIZE_RESET = 7'd64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_FETCH,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       load;
    logic       mem_rd;
    logic       mem_wr;
    logic [1:0] sel;
    logic       mac_en;
    logic       mac_first;
    logic       res_load;
    logic       out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] in_cmd;
    logic             in_inside;
    logic             sample;
  } ctrl_stat_t;

endpackage

>>> design/rbs_ctrl.sv
// Sequencer for the RGBA bilinear sampler: handshakes, neighbor steps, result hand-off.
module rbs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  rbs_pkg::ctrl_stat_t stat,
  output rbs_pkg::ctrl_cmd_t  cmd
);
  import rbs_pkg::*;

  state_t     state, state_next;
  logic [1:0] step, step_next;
  logic       out_valid;
  logic       accept;

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= 2'd0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    cmd.sel    = step;
    unique case (state)
      ST_IDLE: begin
        step_next = 2'd0;
        if (accept) begin
          cmd.load = 1'b1;
          if (!stat.in_inside) begin
            state_next = ST_DONE;
          end else begin
            unique case (stat.in_cmd) inside
              CMD_WRITE:                     state_next = ST_WRITE;
              CMD_READ, CMD_SAMPLE:          state_next = ST_FETCH;
              default:                       state_next = ST_DONE;
            endcase
          end
        end
      end
      ST_WRITE: begin
        cmd.mem_wr = 1'b1;
        cmd.sel    = 2'd0;
        state_next = ST_DONE;
      end
      ST_FETCH: begin
        cmd.mem_rd    = 1'b1;
        cmd.mac_en    = (step != 2'd0);
        cmd.mac_first = (step == 2'd1);
        if (!stat.sample || step == 2'd3) begin
          state_next = ST_DRAIN;
        end else begin
          step_next = step + 2'd1;
        end
      end
      ST_DRAIN: begin
        cmd.res_load = 1'b1;
        state_next   = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || m_axis_tready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> design/rbs_datapath.sv
// Pixel memory, size registers, address and weight logic, and channel accumulators.
module rbs_datapath #(
  parameter int MAX_WIDTH  = rbs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rbs_pkg::DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = rbs_pkg::DEF_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [rbs_pkg::IDX_W-1:0]   cfg_index,
  input  logic [rbs_pkg::CFG_W-1:0]   cfg_data,
  input  logic [rbs_pkg::CMD_W-1:0]   in_cmd,
  input  logic [rbs_pkg::POS_W-1:0]   x_pos,
  input  logic [rbs_pkg::POS_W-1:0]   y_pos,
  input  logic [rbs_pkg::PIX_W-1:0]   pixel_in,
  input  rbs_pkg::ctrl_cmd_t          cmd,
  output rbs_pkg::ctrl_stat_t         stat,
  output logic [rbs_pkg::PIX_W-1:0]   pixel_out,
  output logic                        ok
);
  import rbs_pkg::*;

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int AW    = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int EWW   = $clog2(MAX_WIDTH + 1);
  localparam int EHW   = $clog2(MAX_HEIGHT + 1);
  localparam int IXW   = (POS_W > FRAC_BITS) ? POS_W - FRAC_BITS : 1;
  localparam int CXW   = ((IXW > EWW) ? IXW : EWW) + 1;
  localparam int CYW   = ((IXW > EHW) ? IXW : EHW) + 1;
  localparam int RWW   = (CFG_W > EWW) ? CFG_W : EWW;
  localparam int RHW   = (CFG_W > EHW) ? CFG_W : EHW;
  localparam int FW    = FRAC_BITS + 1;
  localparam int WTW   = 2 * FRAC_BITS + 1;
  localparam int ACW   = 2 * FRAC_BITS + 9;
  localparam int PW    = YW + EWW;

  logic [CFG_W-1:0]     img_w, img_h;
  logic [EWW-1:0]       eff_w;
  logic [EHW-1:0]       eff_h;
  logic [IXW-1:0]       ix, iy;
  logic [FRAC_BITS-1:0] wx_in, wy_in;
  logic                 in_image;
  logic [CXW-1:0]       cx_ext, cx_cl;
  logic [CYW-1:0]       cy_ext, cy_cl;

  logic [CMD_W-1:0]     cmd_q;
  logic [XW-1:0]        fx, cx;
  logic [YW-1:0]        fy, cy;
  logic [FRAC_BITS-1:0] wx, wy;
  logic [PIX_W-1:0]     pixel_q;

  logic [XW-1:0]        col;
  logic [YW-1:0]        row;
  logic [PW-1:0]        row_base;
  logic [AW-1:0]        addr;
  logic [FW-1:0]        one, fxf, fyf;
  logic [WTW-1:0]       wt;

  logic [PIX_W-1:0]     mem [DEPTH];
  logic [PIX_W-1:0]     rdata;

  logic [ACW-1:0]       prod [4];
  logic [ACW-1:0]       acc  [4];
  logic [ACW-1:0]       sum  [4];
  logic [PIX_W-1:0]     smp;
  logic [PIX_W-1:0]     res_pix;
  logic                 res_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      img_w <= IMAGE_SIZE_RESET;
      img_h <= IMAGE_SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  img_w <= cfg_data;
        REG_IMAGE_HEIGHT: img_h <= cfg_data;
        default: ;
      endcase
    end
  end

  assign eff_w = (RWW'(img_w) > RWW'(MAX_WIDTH))  ? EWW'(MAX_WIDTH)  : EWW'(img_w);
  assign eff_h = (RHW'(img_h) > RHW'(MAX_HEIGHT)) ? EHW'(MAX_HEIGHT) : EHW'(img_h);

  assign ix    = IXW'(x_pos >> FRAC_BITS);
  assign iy    = IXW'(y_pos >> FRAC_BITS);
  assign wx_in = FRAC_BITS'(x_pos);
  assign wy_in = FRAC_BITS'(y_pos);

  assign in_image = (CXW'(ix) < CXW'(eff_w)) && (CYW'(iy) < CYW'(eff_h));

  assign cx_ext = (wx_in != '0) ? CXW'(ix) + CXW'(1) : CXW'(ix);
  assign cy_ext = (wy_in != '0) ? CYW'(iy) + CYW'(1) : CYW'(iy);
  assign cx_cl  = (cx_ext >= CXW'(eff_w)) ? CXW'(eff_w) - CXW'(1) : cx_ext;
  assign cy_cl  = (cy_ext >= CYW'(eff_h)) ? CYW'(eff_h) - CYW'(1) : cy_ext;

  assign stat.in_cmd    = in_cmd;
  assign stat.in_inside = in_image;
  assign stat.sample    = (cmd_q == CMD_SAMPLE);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q   <= in_cmd;
      fx      <= XW'(ix);
      fy      <= YW'(iy);
      cx      <= XW'(cx_cl);
      cy      <= YW'(cy_cl);
      wx      <= wx_in;
      wy      <= wy_in;
      pixel_q <= pixel_in;
    end
  end

  assign col      = cmd.sel[0] ? cx : fx;
  assign row      = cmd.sel[1] ? cy : fy;
  assign row_base = PW'(row) * PW'(eff_w);
  assign addr     = AW'(row_base) + AW'(col);

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[addr] <= pixel_q;
    end
    if (cmd.mem_rd) begin
      rdata <= mem[addr];
    end
  end

  assign one = FW'(1) << FRAC_BITS;
  assign fxf = cmd.sel[0] ? FW'(wx) : one - FW'(wx);
  assign fyf = cmd.sel[1] ? FW'(wy) : one - FW'(wy);

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      wt <= WTW'(fxf) * WTW'(fyf);
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      prod[c]       = ACW'(rdata[8*c +: 8]) * ACW'(wt);
      sum[c]        = acc[c] + prod[c];
      smp[8*c +: 8] = sum[c][2*FRAC_BITS +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_en) begin
      for (int c = 0; c < 4; c++) begin
        acc[c] <= cmd.mac_first ? prod[c] : sum[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_pix <= '0;
      res_ok  <= in_image && (in_cmd == CMD_WRITE || in_cmd == CMD_READ ||
                              in_cmd == CMD_SAMPLE);
    end else if (cmd.res_load) begin
      res_pix <= (cmd_q == CMD_SAMPLE) ? smp : rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pixel_out <= res_pix;
      ok        <= res_ok;
    end
  end

endmodule

>>> design/rgba_bilinear_sampler.sv
// RGBA8888 image store with pixel write, pixel read and bilinear sampling.
// Commands arrive one at a time on the slave stream and each gives one result on the
// master stream. The single-port pixel memory serves one access per cycle, which sets
// the pace: a write passes through the write and done states, a read through fetch,
// drain and done, and a bilinear sample reads its four neighbors one after another
// in fetch, then drains and hands off; a position outside the image or an unused
// command goes straight to done. A result waiting in the output register does not
// block the next input transfer; it only holds the block at hand-off.
// Positions are unsigned fixed point with FRAC_BITS fraction bits; the pixel memory has
// no reset, and reading a pixel never written gives an undefined value.
module rgba_bilinear_sampler #(
  parameter int MAX_WIDTH  = rbs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rbs_pkg::DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = rbs_pkg::DEF_FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [rbs_pkg::IDX_W-1:0] cfg_index,
  input  logic [rbs_pkg::CFG_W-1:0] cfg_data,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [63:0]               s_axis_tdata,  // x_pos, y_pos, pixel_in, zero pad
  input  logic [1:0]                s_axis_tuser,  // cmd
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [31:0]               m_axis_tdata,  // pixel_out
  output logic [0:0]                m_axis_tuser   // ok
);
  import rbs_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  rbs_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  rbs_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_cmd    (s_axis_tuser),
    .x_pos     (s_axis_tdata[13:0]),
    .y_pos     (s_axis_tdata[27:14]),
    .pixel_in  (s_axis_tdata[59:28]),
    .cmd       (cmd),
    .stat      (stat),
    .pixel_out (m_axis_tdata),
    .ok        (m_axis_tuser[0])
  );

endmodule

>>> design/rbs_checker.sv
// Port-level checks for the RGBA bilinear sampler, bound to the top level.
module rbs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 32'd0))
    else $error("failed result carries nonzero pixel");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second transfer taken while busy");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result present after reset");

endmodule

bind rgba_bilinear_sampler rbs_checker u_rbs_checker (.*);

>>> tb/tb_rgba_bilinear_sampler.sv
// Self-checking testbench for rgba_bilinear_sampler: directed and random pixel commands.
module tb_rgba_bilinear_sampler;
  timeunit 1ns;
  timeprecision 1ps;
  import rbs_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int FRAC        = DEF_FRAC_BITS;
  localparam int ONE         = 1 << FRAC;
  localparam int DEPTH       = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
  localparam int HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             ok;
  } pixel_result_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [63:0]       s_axis_tdata;
  logic [1:0]        s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [31:0]       m_axis_tdata;
  logic [0:0]        m_axis_tuser;

  logic [CFG_W-1:0]  width_reg = IMAGE_SIZE_RESET;
  logic [CFG_W-1:0]  height_reg = IMAGE_SIZE_RESET;
  logic [PIX_W-1:0]  pixel_mirror [DEPTH];
  bit                pixel_written [DEPTH];
  pixel_result_t     results_due [$];
  pixel_result_t     want;
  int                mismatches = 0;
  int                transfers_sent = 0;
  bit                steady = 1'b0;
  bit                hold_pending = 1'b0;

  rgba_bilinear_sampler dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk = ~clk;

  function automatic int clamp_size(input logic [CFG_W-1:0] r, input int lim);
    return (int'(r) > lim) ? lim : int'(r);
  endfunction

  function automatic logic [PIX_W-1:0] mirror_at(input int x, input int y);
    return pixel_mirror[y * clamp_size(width_reg, DEF_MAX_WIDTH) + x];
  endfunction

  function automatic pixel_result_t sampler_predict(input logic [CMD_W-1:0] cmd,
                                                    input logic [POS_W-1:0] xp, yp,
                                                    input logic [PIX_W-1:0] pin);
    int w, h, ix, iy, cx, cy, wx, wy, ch, k;
    int unsigned acc;
    int unsigned wgt [4];
    logic [PIX_W-1:0] nb [4];
    pixel_result_t r;
    w = clamp_size(width_reg, DEF_MAX_WIDTH);
    h = clamp_size(height_reg, DEF_MAX_HEIGHT);
    ix = xp >> FRAC;
    iy = yp >> FRAC;
    r = '0;
    if (ix >= w || iy >= h) return r;
    case (cmd)
      CMD_WRITE: begin
        pixel_mirror[iy * w + ix] = pin;
        pixel_written[iy * w + ix] = 1'b1;
        r.ok = 1'b1;
      end
      CMD_READ: begin
        r.pixel = mirror_at(ix, iy);
        r.ok = 1'b1;
      end
      CMD_SAMPLE: begin
        wx = xp[FRAC-1:0];
        wy = yp[FRAC-1:0];
        cx = (wx != 0) ? ix + 1 : ix;
        cy = (wy != 0) ? iy + 1 : iy;
        if (cx >= w) cx = w - 1;
        if (cy >= h) cy = h - 1;
        nb[0] = mirror_at(ix, iy);
        nb[1] = mirror_at(cx, iy);
        nb[2] = mirror_at(ix, cy);
        nb[3] = mirror_at(cx, cy);
        wgt[0] = (ONE - wy) * (ONE - wx);
        wgt[1] = wx * (ONE - wy);
        wgt[2] = wy * (ONE - wx);
        wgt[3] = wx * wy;
        for (ch = 0; ch < 4; ch++) begin
          acc = 0;
          for (k = 0; k < 4; k++) acc += nb[k][ch*8 +: 8] * wgt[k];
          r.pixel[ch*8 +: 8] = 8'(acc >> (2 * FRAC));
        end
        r.ok = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void report_mismatch(input string field,
                                          input logic [PIX_W-1:0] exp_v, act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s at %0t: expected %h, got %h", field, $time, exp_v, act_v);
  endfunction

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (results_due.size() == 0) begin
        report_mismatch("unexpected result", 'x, m_axis_tdata);
      end else begin
        want = results_due.pop_front();
        if (m_axis_tdata !== want.pixel) report_mismatch("pixel_out", want.pixel, m_axis_tdata);
        if (m_axis_tuser[0] !== want.ok) report_mismatch("ok", want.ok, m_axis_tuser);
      end
    end
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_axis_tready <= steady || ($urandom_range(99) >= 25);
    end
  end

  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] xp, yp,
                              input logic [PIX_W-1:0] pin);
    int gap;
    @(negedge clk);
    gap = (!steady && $urandom_range(99) < 25) ? $urandom_range(6, 1) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {4'b0, pin, yp, xp};
    do @(posedge clk); while (!s_axis_tready);
    results_due.push_back(sampler_predict(cmd, xp, yp, pin));
    transfers_sent++;
  endtask

  // write any pixel the command would fetch that holds no defined value yet
  task automatic fill_neighbors(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] xp, yp);
    int w, h, ix, iy, cx, cy, px, py, j;
    if (cmd != CMD_READ && cmd != CMD_SAMPLE) return;
    w = clamp_size(width_reg, DEF_MAX_WIDTH);
    h = clamp_size(height_reg, DEF_MAX_HEIGHT);
    ix = xp >> FRAC;
    iy = yp >> FRAC;
    if (ix >= w || iy >= h) return;
    cx = ix;
    cy = iy;
    if (cmd == CMD_SAMPLE) begin
      if (xp[FRAC-1:0] != 0 && ix + 1 < w) cx = ix + 1;
      if (yp[FRAC-1:0] != 0 && iy + 1 < h) cy = iy + 1;
    end
    for (j = 0; j < 4; j++) begin
      px = j[0] ? cx : ix;
      py = j[1] ? cy : iy;
      if (!pixel_written[py * w + px])
        send_command(CMD_WRITE, POS_W'((px << FRAC) | $urandom_range(ONE - 1)),
                     POS_W'((py << FRAC) | $urandom_range(ONE - 1)), $urandom);
    end
  endtask

  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] xp, yp,
                       input logic [PIX_W-1:0] pin);
    fill_neighbors(cmd, xp, yp);
    send_command(cmd, xp, yp, pin);
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  task automatic set_image_size(input int w, input int h);
    write_register(REG_IMAGE_WIDTH, CFG_W'(w));
    write_register(REG_IMAGE_HEIGHT, CFG_W'(h));
  endtask

  function automatic logic [POS_W-1:0] pick_pos(input int span);
    int roll, whole, frac;
    roll = $urandom_range(99);
    if (span == 0 || roll < 8) return POS_W'($urandom);
    whole = (roll < 14 && span < DEF_MAX_WIDTH) ? span : $urandom_range(span - 1);
    roll = $urandom_range(9);
    frac = (roll < 3) ? 0 : (roll == 3) ? ONE - 1 : $urandom_range(ONE - 1);
    return POS_W'((whole << FRAC) | frac);
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd();
    int roll;
    roll = $urandom_range(99);
    if (roll < 30) return CMD_WRITE;
    if (roll < 55) return CMD_READ;
    if (roll < 95) return CMD_SAMPLE;
    return CMD_UNUSED;
  endfunction

  task automatic run_random(input int count);
    int stop;
    stop = transfers_sent + count;
    while (transfers_sent < stop)
      issue(pick_cmd(), pick_pos(clamp_size(width_reg, DEF_MAX_WIDTH)),
            pick_pos(clamp_size(height_reg, DEF_MAX_HEIGHT)), $urandom);
    drain_results();
  endtask

  task automatic test_reset_size_corners();
    issue(CMD_WRITE, 14'h0000, 14'h0000, 32'hFF00_FF00);
    issue(CMD_WRITE, 14'h0100, 14'h0000, 32'h00FF_00FF);
    issue(CMD_WRITE, 14'h0000, 14'h0100, 32'hFFFF_FFFF);
    issue(CMD_WRITE, 14'h01FF, 14'h01FF, 32'h0000_0000);
    issue(CMD_WRITE, 14'h3FFF, 14'h3FFF, 32'h8040_2010);
    issue(CMD_READ, 14'h0000, 14'h0000, 32'h0);
    issue(CMD_READ, 14'h3FFF, 14'h3FFF, 32'hFFFF_FFFF);
    issue(CMD_SAMPLE, 14'h0000, 14'h0000, 32'h0);
    issue(CMD_SAMPLE, 14'h0080, 14'h0080, 32'h0);
    issue(CMD_SAMPLE, 14'h00FF, 14'h00FF, 32'h0);
    issue(CMD_SAMPLE, 14'h00FF, 14'h0000, 32'h0);
    issue(CMD_SAMPLE, 14'h0000, 14'h0040, 32'h0);
    issue(CMD_SAMPLE, 14'h3FFF, 14'h3FFF, 32'h0);
    issue(CMD_UNUSED, 14'h0000, 14'h0000, 32'hFFFF_FFFF);
    drain_results();
  endtask

  task automatic test_small_image_edges();
    set_image_size(4, 2);
    issue(CMD_WRITE, 14'h0300, 14'h0100, 32'hA5C3_3C5A);
    issue(CMD_WRITE, 14'h0400, 14'h0000, 32'h1111_1111);
    issue(CMD_WRITE, 14'h0000, 14'h0200, 32'h2222_2222);
    issue(CMD_READ, 14'h0400, 14'h0100, 32'h0);
    issue(CMD_READ, 14'h0300, 14'h0100, 32'h0);
    issue(CMD_SAMPLE, 14'h0380, 14'h0180, 32'h0);
    issue(CMD_SAMPLE, 14'h0400, 14'h0000, 32'h0);
    issue(CMD_SAMPLE, 14'h0080, 14'h0280, 32'h0);
    issue(CMD_READ, 14'h3FFF, 14'h3FFF, 32'h0);
    drain_results();
  endtask

  task automatic test_random_sizes();
    int sizes [10][2] = '{'{64, 64}, '{5, 3}, '{1, 1}, '{0, 9}, '{12, 0},
                          '{127, 100}, '{64, 1}, '{1, 64}, '{2, 2}, '{65, 127}};
    int lengths [10] = '{150, 100, 40, 20, 20, 150, 60, 60, 50, 80};
    int p;
    for (p = 0; p < 10; p++) begin
      set_image_size(sizes[p][0], sizes[p][1]);
      run_random(lengths[p]);
    end
    for (p = 0; p < 3; p++) begin
      set_image_size($urandom_range(64, 1), $urandom_range(64, 1));
      run_random(50);
    end
  endtask

  task automatic test_full_rate_stream();
    set_image_size(16, 16);
    steady = 1'b1;
    run_random(150);
    steady = 1'b0;
  endtask

  task automatic test_output_backpressure();
    set_image_size(8, 8);
    hold_pending = 1'b1;
    run_random(40);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_size_corners();
    test_small_image_edges();
    test_random_sizes();
    test_full_rate_stream();
    test_output_backpressure();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
